@@ design/delay_and_sum_beamformer_unit_defines.svh @@
// assertion macros used by the beamformer rtl
`ifndef DELAY_AND_SUM_BEAMFORMER_UNIT_DEFINES_SVH
`define DELAY_AND_SUM_BEAMFORMER_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define BFU_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define BFU_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/bfu_pkg.sv @@
// constants, types and register codes of the beamformer
`default_nettype none
package bfu_pkg;
    localparam int NUM_ELEMENTS = 128;
    localparam int NUM_SAMPLES  = 4096;
    localparam int MAX_PIXELS   = 64;

    localparam int STORE_DEPTH = NUM_ELEMENTS * NUM_SAMPLES;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int EL_W        = (NUM_ELEMENTS > 1) ? $clog2(NUM_ELEMENTS) : 1;
    localparam int PIX_W       = $clog2(MAX_PIXELS);
    localparam int NPIX_W      = PIX_W + 1;

    // field widths
    localparam int STEP_W  = 16;
    localparam int PITCH_W = 12;
    localparam int RATE_W  = 24;
    localparam int NPCFG_W = 7;
    localparam int EIDX_W  = 7;
    localparam int SIDX_W  = 12;
    localparam int RF_W    = 16;
    localparam int Z_W     = 22;
    localparam int ZH_W    = Z_W + 1;
    localparam int MAG_W   = 23;
    localparam logic [MAG_W-1:0] MAG_MAX = '1;

    // datapath widths
    localparam int ACC_W   = RF_W + EL_W + 1;
    localparam int AX_W    = EL_W + 1 + PITCH_W;
    localparam int RAD_W   = (2 * ACC_W + 2 > 48) ? 2 * ACC_W + 2 : 48;
    localparam int ROOT_W  = RAD_W / 2;
    localparam int D_W     = ZH_W + 2;
    localparam int PROD_W  = D_W + RATE_W;
    localparam int SMP_SHIFT = 25;
    localparam int SMP_W   = PROD_W - SMP_SHIFT;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_STEP = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_PIXELS = 3'd3;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_START = 1'b1;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int Q_W         = $clog2(QUEUE_DEPTH);

    typedef enum logic {K_LOAD, K_START} t_kind;

    typedef struct packed {
        t_kind                kind;
        logic [ADDR_W-1:0]    addr;
        logic [2*RF_W-1:0]    data;
    } t_cmd;

    typedef struct packed {
        logic [STEP_W-1:0]  pixel_step_um;
        logic [PITCH_W-1:0] pitch_um;
        logic [RATE_W-1:0]  samples_per_um_q24;
        logic [NPCFG_W-1:0] num_pixels;
    } t_cfg;
endpackage
`default_nettype wire

@@ design/bfu_ifs.sv @@
// item channels of the beamformer
`default_nettype none
interface bfu_cfg_if;
    import bfu_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

interface bfu_in_if;
    import bfu_pkg::*;
    logic                     valid;
    logic                     ready;
    logic                     command;
    logic [EIDX_W-1:0]        element_index;
    logic [SIDX_W-1:0]        sample_index;
    logic signed [RF_W-1:0]   rf_real;
    logic signed [RF_W-1:0]   rf_imag;
    modport source (output valid, command, element_index, sample_index, rf_real, rf_imag,
                    input ready);
    modport sink   (input valid, command, element_index, sample_index, rf_real, rf_imag,
                    output ready);
endinterface

interface bfu_out_if;
    import bfu_pkg::*;
    logic              valid;
    logic              ready;
    logic [Z_W-1:0]    pixel_depth_um;
    logic [MAG_W-1:0]  magnitude;
    logic              out_of_range;
    logic              last;
    modport source (output valid, pixel_depth_um, magnitude, out_of_range, last,
                    input ready);
    modport sink   (input valid, pixel_depth_um, magnitude, out_of_range, last,
                    output ready);
endinterface
`default_nettype wire

@@ design/bfu_ram.sv @@
// generic single-port-write ram with registered read
`default_nettype none
module bfu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

@@ design/bfu_front.sv @@
// front end: accepts items, classifies them and queues commands
`default_nettype none
module bfu_front (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    bfu_in_if.sink       i_in,
    output bfu_pkg::t_cmd o_cmd,
    output logic         o_cmd_valid,
    input  wire logic    i_cmd_pop
);
    import bfu_pkg::*;

    t_cmd             r_q [QUEUE_DEPTH];
    logic [Q_W-1:0]   r_wp;
    logic [Q_W-1:0]   r_rp;
    logic [Q_W:0]     r_cnt;
    logic             acc;
    logic             load_ok;
    logic             push;
    logic             pop;
    t_cmd             cmd;

    // classify the incoming item
    always_comb begin
        load_ok = (32'(i_in.element_index) < 32'(NUM_ELEMENTS))
                  && (32'(i_in.sample_index) < 32'(NUM_SAMPLES));
        cmd.kind = (i_in.command == CMD_START) ? K_START : K_LOAD;
        cmd.addr = ADDR_W'(ADDR_W'(i_in.element_index) * ADDR_W'(NUM_SAMPLES)
                   + ADDR_W'(i_in.sample_index));
        cmd.data = {i_in.rf_real, i_in.rf_imag};
    end

    assign i_in.ready  = (r_cnt != (Q_W+1)'(QUEUE_DEPTH));
    assign acc         = i_in.valid && i_in.ready;
    assign push        = acc && ((i_in.command == CMD_START) || load_ok);
    assign pop         = i_cmd_pop && o_cmd_valid;
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= Q_W'(r_wp + 1'b1);
            end
            if (pop) begin
                r_rp <= Q_W'(r_rp + 1'b1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

@@ design/bfu_sqrt.sv @@
// iterative integer square root, one result bit per cycle
`default_nettype none
module bfu_sqrt (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [bfu_pkg::RAD_W-1:0]  i_rad,
    output      logic                       o_busy,
    output      logic                       o_done,
    output      logic [bfu_pkg::ROOT_W-1:0] o_root
);
    import bfu_pkg::*;

    localparam int REM_W = ROOT_W + 3;
    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic [RAD_W-1:0]  r_rad;
    logic [REM_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_cnt;
    logic [REM_W-1:0]  rem_t;
    logic [REM_W-1:0]  trial;
    logic              fits;

    // one restoring step
    always_comb begin
        rem_t = {r_rem[ROOT_W:0], r_rad[RAD_W-1 -: 2]};
        trial = {1'b0, o_root, 2'b01};
        fits  = (rem_t >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                o_busy <= 1'b1;
                r_rad  <= i_rad;
                r_rem  <= '0;
                o_root <= '0;
                r_cnt  <= '0;
            end else if (o_busy) begin
                r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
                r_rem  <= fits ? REM_W'(rem_t - trial) : rem_t;
                o_root <= {o_root[ROOT_W-2:0], fits};
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(ROOT_W - 1)) begin
                    o_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

@@ design/bfu_back.sv @@
// back end: sample store writes and the per-pixel delay-and-sum sequencer
`default_nettype none
`include "delay_and_sum_beamformer_unit_defines.svh"
module bfu_back (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  bfu_pkg::t_cfg i_cfg,
    input  bfu_pkg::t_cmd i_cmd,
    input  wire logic     i_cmd_valid,
    output logic          o_cmd_pop,
    bfu_out_if.source     o_out
);
    import bfu_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_GEOM, S_RAD, S_ROOT_GO, S_ROOT_WAIT, S_MUL, S_IDX, S_RD, S_NEXT,
        S_MSQ, S_MRAD, S_MROOT_GO, S_MROOT_WAIT, S_OUT
    } t_state;

    t_state                r_state;
    logic [PIX_W-1:0]      r_pix;
    logic [NPIX_W-1:0]     r_npix;
    logic [EL_W-1:0]       r_el;
    logic [Z_W-1:0]        r_z;
    logic [2*ZH_W-1:0]     r_zsq;
    logic [AX_W-1:0]       r_ax;
    logic [RAD_W-1:0]      r_rad;
    logic [D_W-1:0]        r_d;
    logic [PROD_W-1:0]     r_prod;
    logic [2*ACC_W-1:0]    r_sqr;
    logic signed [ACC_W-1:0] r_acc_re;
    logic signed [ACC_W-1:0] r_acc_im;
    logic                  r_oor;

    logic [ZH_W-1:0]       zh;
    logic [2*ZH_W-1:0]     zsq;
    logic signed [EL_W+1:0] off;
    logic [EL_W:0]         aoff;
    logic [AX_W-1:0]       ax;
    logic [2*AX_W-1:0]     xsq;
    logic [D_W-1:0]        d;
    logic [PROD_W-1:0]     prod;
    logic [SMP_W-1:0]      smp;
    logic                  smp_oor;
    logic [ACC_W-1:0]      ar;
    logic [ACC_W-1:0]      ai;
    logic [2*ACC_W-1:0]    sq_re;
    logic [2*ACC_W-1:0]    sq_im;
    logic [NPCFG_W-1:0]    npix_cfg;
    logic [NPIX_W-1:0]     npix;

    logic                  sq_start;
    logic                  sq_busy;
    logic                  sq_done;
    logic [ROOT_W-1:0]     sq_root;
    logic                  ram_we;
    logic                  ram_re;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [2*RF_W-1:0]     ram_rdata;
    logic                  out_take;

    // geometry and delay arithmetic
    always_comb begin
        zh      = {r_z, 1'b0};
        zsq     = zh * zh;
        off     = $signed({1'b0, r_el, 1'b0}) - $signed((EL_W+2)'(NUM_ELEMENTS - 1));
        aoff    = off[EL_W+1] ? (EL_W+1)'(-off) : (EL_W+1)'(off);
        ax      = aoff * i_cfg.pitch_um;
        xsq     = r_ax * r_ax;
        d       = D_W'(zh) + D_W'(sq_root);
        prod    = r_d * i_cfg.samples_per_um_q24;
        smp     = r_prod[PROD_W-1:SMP_SHIFT];
        smp_oor = (32'(smp) >= 32'(NUM_SAMPLES));
        ram_raddr = ADDR_W'(ADDR_W'(r_el) * ADDR_W'(NUM_SAMPLES) + ADDR_W'(smp));
        ar      = r_acc_re[ACC_W-1] ? ACC_W'(-r_acc_re) : ACC_W'(r_acc_re);
        ai      = r_acc_im[ACC_W-1] ? ACC_W'(-r_acc_im) : ACC_W'(r_acc_im);
        sq_re   = ar * ar;
        sq_im   = ai * ai;
    end

    // pixel count clamp
    always_comb begin
        npix_cfg = i_cfg.num_pixels;
        if (npix_cfg == '0) begin
            npix = NPIX_W'(1);
        end else if (32'(npix_cfg) > 32'(MAX_PIXELS)) begin
            npix = NPIX_W'(MAX_PIXELS);
        end else begin
            npix = NPIX_W'(npix_cfg);
        end
    end

    // handshakes and strobes
    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid;
    assign ram_we    = o_cmd_pop && (i_cmd.kind == K_LOAD);
    assign ram_re    = (r_state == S_IDX) && !smp_oor;
    assign sq_start  = (r_state == S_ROOT_GO) || (r_state == S_MROOT_GO);
    assign out_take  = o_out.valid && o_out.ready;

    bfu_ram #(
        .WIDTH (2 * RF_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_cmd.addr),
        .i_wdata (i_cmd.data),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    bfu_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_rad   (r_rad),
        .o_busy  (sq_busy),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    // sequencer with registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pix       <= '0;
            r_el        <= '0;
            r_acc_re    <= '0;
            r_acc_im    <= '0;
            r_oor       <= 1'b0;
            o_out.valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid && (i_cmd.kind == K_START)) begin
                        r_pix    <= '0;
                        r_z      <= '0;
                        r_el     <= '0;
                        r_npix   <= npix;
                        r_acc_re <= '0;
                        r_acc_im <= '0;
                        r_oor    <= 1'b0;
                        r_state  <= S_GEOM;
                    end
                end
                S_GEOM: begin
                    r_zsq   <= zsq;
                    r_ax    <= ax;
                    r_state <= S_RAD;
                end
                S_RAD: begin
                    r_rad   <= RAD_W'(r_zsq) + RAD_W'(xsq);
                    r_state <= S_ROOT_GO;
                end
                S_ROOT_GO: begin
                    r_state <= S_ROOT_WAIT;
                end
                S_ROOT_WAIT: begin
                    if (sq_done) begin
                        r_d     <= d;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= prod;
                    r_state <= S_IDX;
                end
                S_IDX: begin
                    if (smp_oor) begin
                        r_oor   <= 1'b1;
                        r_state <= S_NEXT;
                    end else begin
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_acc_re <= r_acc_re + ACC_W'($signed(ram_rdata[2*RF_W-1:RF_W]));
                    r_acc_im <= r_acc_im + ACC_W'($signed(ram_rdata[RF_W-1:0]));
                    r_state  <= S_NEXT;
                end
                S_NEXT: begin
                    if (r_el == EL_W'(NUM_ELEMENTS - 1)) begin
                        r_state <= S_MSQ;
                    end else begin
                        r_el    <= r_el + 1'b1;
                        r_state <= S_GEOM;
                    end
                end
                S_MSQ: begin
                    r_sqr   <= sq_re;
                    r_state <= S_MRAD;
                end
                S_MRAD: begin
                    r_rad   <= RAD_W'(r_sqr) + RAD_W'(sq_im);
                    r_state <= S_MROOT_GO;
                end
                S_MROOT_GO: begin
                    r_state <= S_MROOT_WAIT;
                end
                S_MROOT_WAIT: begin
                    if (sq_done) begin
                        o_out.valid          <= 1'b1;
                        o_out.pixel_depth_um <= r_z;
                        o_out.magnitude      <= (sq_root > ROOT_W'(MAG_MAX))
                                                ? MAG_MAX : MAG_W'(sq_root);
                        o_out.out_of_range   <= r_oor;
                        o_out.last           <= (NPIX_W'(r_pix) + 1'b1 == r_npix);
                        r_state              <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_take) begin
                        o_out.valid <= 1'b0;
                        if (o_out.last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_pix    <= r_pix + 1'b1;
                            r_z      <= r_z + Z_W'(i_cfg.pixel_step_um);
                            r_el     <= '0;
                            r_acc_re <= '0;
                            r_acc_im <= '0;
                            r_oor    <= 1'b0;
                            r_state  <= S_GEOM;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // checks
    `BFU_ASSERT_IMP(a_sqrt_free, i_clk, i_rst_n, sq_start, !sq_busy, "sqrt started while busy")
    `BFU_ASSERT_NXT(a_read_then_acc, i_clk, i_rst_n, ram_re, r_state == S_RD, "read without acc")
    `BFU_ASSERT_IMP(a_write_idle, i_clk, i_rst_n, ram_we, !o_out.valid, "store write mid scan")
endmodule
`default_nettype wire

@@ design/delay_and_sum_beamformer_unit.sv @@
// top level of the delay-and-sum a-mode beamformer
// Channels: i_cfg writes one register per item (0 pixel step, 1 pitch, 2 rate,
// 3 pixel count) and is always ready. i_in carries load and start items; o_out
// carries one item per pixel with depth, magnitude, range flag and last.
// A load item is queued by the front end and written to the sample store at
// the edge where it leaves the queue, so loads run at one per cycle while the
// sequencer is idle and wait in the queue while a scanline runs.
// A start item runs the sequencer: per element the geometry multiplies, a
// 25-step square root, the delay multiply and a store read, then per pixel
// the magnitude root; the shared iterative square root and the single store
// read port set the time a scanline takes.
// The four-entry queue keeps accepting items until it is full while a scanline
// runs or a result waits; when the receiver stalls o_out holds its item and the
// scanline pauses until it is taken.
// Reset clears the queue, the sequencer and the registers to their defaults;
// the sample store is not cleared and must be loaded before it is used.
`default_nettype none
module delay_and_sum_beamformer_unit (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    bfu_cfg_if.sink   i_cfg,
    bfu_in_if.sink    i_in,
    bfu_out_if.source o_out
);
    import bfu_pkg::*;

    t_cfg r_cfg;
    t_cmd cmd;
    logic cmd_valid;
    logic cmd_pop;

    // configuration registers
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pixel_step_um      <= STEP_W'(1000);
            r_cfg.pitch_um           <= PITCH_W'(300);
            r_cfg.samples_per_um_q24 <= RATE_W'(272366);
            r_cfg.num_pixels         <= NPCFG_W'(64);
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_PIXEL_STEP: r_cfg.pixel_step_um      <= i_cfg.data[STEP_W-1:0];
                CFG_PITCH:      r_cfg.pitch_um           <= i_cfg.data[PITCH_W-1:0];
                CFG_RATE:       r_cfg.samples_per_um_q24 <= i_cfg.data[RATE_W-1:0];
                CFG_NUM_PIXELS: r_cfg.num_pixels         <= i_cfg.data[NPCFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    bfu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop)
    );

    bfu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .o_out       (o_out)
    );
endmodule
`default_nettype wire
